### rtl/core/mfde_pkg.sv
`default_nettype none

package mfde_pkg;

  // Panel geometry
  localparam int WIDTH_PIXELS  = 128;
  localparam int HEIGHT_PIXELS = 64;
  localparam int PAGE_COUNT    = HEIGHT_PIXELS / 8;
  localparam int STORE_BYTES   = WIDTH_PIXELS * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  // Coordinate widths: columns reach pos_x + rect_width - 1, rows pos_y + rect_height - 1
  localparam int XW  = 9;
  localparam int YW  = 8;
  localparam int PGW = YW - 3;

  localparam logic [XW-1:0]  X_MAX    = XW'(WIDTH_PIXELS - 1);
  localparam logic [PGW-1:0] PAGE_MAX = PGW'(PAGE_COUNT - 1);
  localparam logic [YW-1:0]  ROW_LAST = YW'(PAGE_COUNT * 8 - 1);

  localparam int SQUARE_SIDE = 8;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_RECT   = 3'd1,
    MODE_SQUARE = 3'd2,
    MODE_PIXEL  = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_DRAW,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_READ,
    B_DONE
  } back_state_t;

  // One classified command: a clipped byte walk, a store read, or nothing
  typedef struct packed {
    op_t            op;
    logic           is_read;
    logic [XW-1:0]  left;
    logic [XW-1:0]  right;
    logic [XW-1:0]  col_last;
    logic [YW-1:0]  top;
    logic [YW-1:0]  bot;
    logic [PGW-1:0] page_first;
    logic [PGW-1:0] page_last;
    logic           fill;
    logic           color;
    logic [9:0]     byte_index;
  } job_t;

  // Whole-panel fill, used by the clear command and the reset sweep
  function automatic job_t clear_job(input logic color);
    job_t j;
    j            = '0;
    j.op         = OP_DRAW;
    j.is_read    = 1'b0;
    j.left       = '0;
    j.right      = X_MAX;
    j.col_last   = X_MAX;
    j.top        = '0;
    j.bot        = ROW_LAST;
    j.page_first = '0;
    j.page_last  = PAGE_MAX;
    j.fill       = 1'b1;
    j.color      = color;
    return j;
  endfunction

endpackage

`default_nettype wire

### rtl/core/mfde_if.sv
`default_nettype none

// Command channel
interface mfde_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [6:0] pos_x;
  logic [5:0] pos_y;
  logic [7:0] rect_width;
  logic [6:0] rect_height;
  logic       color;
  logic [9:0] byte_index;

  modport source (output valid, mode, pos_x, pos_y, rect_width, rect_height, color,
                  byte_index, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, rect_width, rect_height, color,
                  byte_index, output ready);
endinterface

// Result channel
interface mfde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       is_read;

  modport source (output valid, read_data, is_read, input ready);
  modport sink   (input valid, read_data, is_read, output ready);
endinterface

`default_nettype wire

### rtl/core/mfde_front.sv
`default_nettype none

module mfde_front (
  mfde_in_if.sink           in_ch,
  input  wire logic         init_busy,
  input  wire logic         q_full,
  output logic              q_push,
  output mfde_pkg::job_t    q_job
);

  mfde_pkg::job_t job;
  logic           draw;

  // Take an item whenever the queue has room and the store is not being swept
  assign in_ch.ready = !q_full && !init_busy;
  assign q_push      = in_ch.valid && in_ch.ready;
  assign q_job       = job;

  // Classify the command into a clipped byte walk, a read or nothing
  always_comb begin
    job            = '0;
    job.op         = mfde_pkg::OP_NOP;
    job.is_read    = 1'b0;
    job.fill       = 1'b1;
    job.color      = in_ch.color;
    job.left       = mfde_pkg::XW'(in_ch.pos_x);
    job.top        = mfde_pkg::YW'(in_ch.pos_y);
    job.right      = mfde_pkg::XW'(in_ch.pos_x);
    job.bot        = mfde_pkg::YW'(in_ch.pos_y);
    job.byte_index = in_ch.byte_index;
    draw           = 1'b0;

    case (in_ch.mode)
      mfde_pkg::MODE_CLEAR: begin
        job = mfde_pkg::clear_job(in_ch.color);
      end
      mfde_pkg::MODE_RECT: begin
        if (in_ch.rect_width != 8'd0 && in_ch.rect_height != 7'd0) begin
          draw      = 1'b1;
          job.right = mfde_pkg::XW'(in_ch.pos_x) + mfde_pkg::XW'(in_ch.rect_width)
                      - mfde_pkg::XW'(1);
          job.bot   = mfde_pkg::YW'(in_ch.pos_y) + mfde_pkg::YW'(in_ch.rect_height)
                      - mfde_pkg::YW'(1);
          // lit draws the outline, dark clears the whole area
          job.fill  = !in_ch.color;
        end
      end
      mfde_pkg::MODE_SQUARE: begin
        draw      = 1'b1;
        job.right = mfde_pkg::XW'(in_ch.pos_x) + mfde_pkg::XW'(mfde_pkg::SQUARE_SIDE - 1);
        job.bot   = mfde_pkg::YW'(in_ch.pos_y) + mfde_pkg::YW'(mfde_pkg::SQUARE_SIDE - 1);
        job.color = 1'b1;
      end
      mfde_pkg::MODE_PIXEL: begin
        draw = 1'b1;
      end
      mfde_pkg::MODE_READ: begin
        job.is_read = 1'b1;
        job.op      = (32'(in_ch.byte_index) < mfde_pkg::STORE_BYTES) ?
                      mfde_pkg::OP_READ : mfde_pkg::OP_NOP;
      end
      default: ;
    endcase

    // Clip to the panel; an origin off the panel draws nothing
    if (draw && job.left <= mfde_pkg::X_MAX &&
        job.top[mfde_pkg::YW-1:3] <= mfde_pkg::PAGE_MAX) begin
      job.op         = mfde_pkg::OP_DRAW;
      job.col_last   = (job.right > mfde_pkg::X_MAX) ? mfde_pkg::X_MAX : job.right;
      job.page_first = job.top[mfde_pkg::YW-1:3];
      job.page_last  = (job.bot[mfde_pkg::YW-1:3] > mfde_pkg::PAGE_MAX) ?
                       mfde_pkg::PAGE_MAX : job.bot[mfde_pkg::YW-1:3];
    end
  end

endmodule

`default_nettype wire

### rtl/core/mfde_queue.sv
`default_nettype none

module mfde_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mfde_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output mfde_pkg::job_t       pop_job,
  output logic                 valid
);

  mfde_pkg::job_t                 entry_r [mfde_pkg::QUEUE_DEPTH];
  logic [mfde_pkg::QAW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [mfde_pkg::QAW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [mfde_pkg::QAW:0]         count_r, count_nxt;

  assign full    = (count_r == (mfde_pkg::QAW+1)'(mfde_pkg::QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign pop_job = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mfde_pkg::QAW'(mfde_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + mfde_pkg::QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mfde_pkg::QAW'(mfde_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + mfde_pkg::QAW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (mfde_pkg::QAW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (mfde_pkg::QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mfde_back.sv
`default_nettype none

module mfde_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire mfde_pkg::job_t  q_job,
  output logic                 q_pop,
  output logic                 init_busy,
  mfde_out_if.source           out_ch
);

  logic [7:0] mem [mfde_pkg::STORE_BYTES];

  mfde_pkg::back_state_t          state_r, state_nxt;
  mfde_pkg::job_t                 job_r, job_nxt;
  logic [mfde_pkg::XW-1:0]        col_r, col_nxt;
  logic [mfde_pkg::PGW-1:0]       page_r, page_nxt;
  logic                           init_r, init_nxt;
  logic                           s1_valid_r, s1_valid_nxt;
  logic [mfde_pkg::ADDR_W-1:0]    s1_addr_r, s1_addr_nxt;
  logic [7:0]                     s1_mask_r, s1_mask_nxt;
  logic                           s1_set_r, s1_set_nxt;
  logic [7:0]                     rd_data_r;
  logic [7:0]                     res_data_r, res_data_nxt;
  logic                           res_is_read_r, res_is_read_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [7:0]                     out_data_r;
  logic                           out_is_read_r;

  logic [mfde_pkg::ADDR_W-1:0]    cur_addr;
  logic [mfde_pkg::ADDR_W-1:0]    rd_addr;
  logic [7:0]                     mask;
  logic [7:0]                     wr_data;
  logic                           edge_col;
  logic                           last_byte;
  logic                           out_load;

  assign init_busy     = init_r;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.is_read   = out_is_read_r;

  // Byte address and bit mask of the current walk position
  assign cur_addr  = mfde_pkg::ADDR_W'(int'(col_r) * mfde_pkg::PAGE_COUNT + int'(page_r));
  assign edge_col  = job_r.fill || (col_r == job_r.left) || (col_r == job_r.right);
  assign last_byte = (page_r == job_r.page_last) && (col_r == job_r.col_last);

  always_comb begin
    logic [mfde_pkg::YW-1:0] row;
    for (int b = 0; b < 8; b++) begin
      row     = {page_r, 3'(b)};
      mask[b] = (row >= job_r.top) && (row <= job_r.bot) &&
                (edge_col || (row == job_r.top) || (row == job_r.bot));
    end
  end

  // Merge the mask into the byte read in the previous cycle
  assign wr_data = s1_set_r ? (rd_data_r | s1_mask_r) : (rd_data_r & ~s1_mask_r);

  // Sequence commands: walk bytes, read, or answer at once
  always_comb begin
    state_nxt       = state_r;
    job_nxt         = job_r;
    col_nxt         = col_r;
    page_nxt        = page_r;
    init_nxt        = init_r;
    s1_valid_nxt    = 1'b0;
    s1_addr_nxt     = cur_addr;
    s1_mask_nxt     = mask;
    s1_set_nxt      = job_r.color;
    rd_addr         = cur_addr;
    res_data_nxt    = res_data_r;
    res_is_read_nxt = res_is_read_r;
    q_pop           = 1'b0;
    out_load        = 1'b0;

    case (state_r)
      mfde_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          case (q_job.op)
            mfde_pkg::OP_DRAW: begin
              col_nxt   = q_job.left;
              page_nxt  = q_job.page_first;
              state_nxt = mfde_pkg::B_RUN;
            end
            mfde_pkg::OP_READ: begin
              rd_addr   = mfde_pkg::ADDR_W'(q_job.byte_index);
              state_nxt = mfde_pkg::B_READ;
            end
            default: begin
              res_data_nxt    = 8'd0;
              res_is_read_nxt = q_job.is_read;
              state_nxt       = mfde_pkg::B_DONE;
            end
          endcase
        end
      end
      mfde_pkg::B_RUN: begin
        s1_valid_nxt = 1'b1;
        if (page_r == job_r.page_last) begin
          page_nxt = job_r.page_first;
          col_nxt  = col_r + mfde_pkg::XW'(1);
        end else begin
          page_nxt = page_r + mfde_pkg::PGW'(1);
        end
        if (last_byte) begin
          state_nxt = mfde_pkg::B_DRAIN;
        end
      end
      mfde_pkg::B_DRAIN: begin
        // Last write lands this cycle; the reset sweep gives no result
        if (init_r) begin
          init_nxt  = 1'b0;
          state_nxt = mfde_pkg::B_IDLE;
        end else begin
          res_data_nxt    = 8'd0;
          res_is_read_nxt = 1'b0;
          state_nxt       = mfde_pkg::B_DONE;
        end
      end
      mfde_pkg::B_READ: begin
        res_data_nxt    = rd_data_r;
        res_is_read_nxt = 1'b1;
        state_nxt       = mfde_pkg::B_DONE;
      end
      mfde_pkg::B_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = mfde_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = mfde_pkg::B_IDLE;
      end
    endcase
  end

  // Hold or drop the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfde_pkg::B_RUN;
      job_r       <= mfde_pkg::clear_job(1'b0);
      col_r       <= '0;
      page_r      <= '0;
      init_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      col_r       <= col_nxt;
      page_r      <= page_nxt;
      init_r      <= init_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_addr_r     <= s1_addr_nxt;
    s1_mask_r     <= s1_mask_nxt;
    s1_set_r      <= s1_set_nxt;
    res_data_r    <= res_data_nxt;
    res_is_read_r <= res_is_read_nxt;
    if (out_load) begin
      out_data_r    <= res_data_r;
      out_is_read_r <= res_is_read_r;
    end
  end

  // Frame store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      mem[s1_addr_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/mono_framebuffer_draw_engine.sv
`default_nettype none

// Channel  Modport  Handshake      Payload
// in_ch    sink     valid/ready    mode, pos_x, pos_y, rect_width, rect_height, color,
//                                  byte_index
// out_ch   source   valid/ready    read_data, is_read
//
// After reset the store is swept to zero, one byte a cycle, then through the drain
// state; in_ch.ready stays low until the sweep ends.
// A clear walks every store byte and a draw every store byte it touches (clipped
// columns times pages), one byte a cycle, set by the single write port of the frame
// store; a read passes through the read state, an empty command straight to the result.
// Up to two commands wait in the queue while one executes; a stalled result sits in
// the output register and holds the back end only once the next result is ready.

module mono_framebuffer_draw_engine (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfde_in_if.sink    in_ch,
  mfde_out_if.source out_ch
);

  logic           init_busy;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  mfde_pkg::job_t push_job;
  mfde_pkg::job_t pop_job;

  mfde_front u_front (
    .in_ch     (in_ch),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  mfde_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .valid    (q_valid)
  );

  mfde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_no_accept_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !in_ch.ready)
    else $error("item accepted during clearing sweep");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("command queue overrun");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue underrun");

  a_reset_starts_sweep: assert property (@(posedge clk)
    $rose(rst_n) |-> init_busy)
    else $error("clearing sweep not active after reset");
`endif

endmodule

`default_nettype wire

### bench/mfde_draw_checker.sv
`default_nettype none

module mfde_draw_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  mfde_in_if        in_mon,
  mfde_out_if       out_mon,
  output int        fail_count,
  output int        pending,
  output int        cmd_count,
  output int        reply_count,
  output int        lit_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  import mfde_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_read;
  } reply_t;

  logic [7:0] shadow_frame [STORE_BYTES];
  reply_t     expected_replies [$];

  // Write one pixel of the shadow frame; drop anything off the panel
  function automatic void plot(input int x, input int y, input bit lit);
    int         idx;
    logic [7:0] mask;
    if (x >= WIDTH_PIXELS || (y >> 3) >= PAGE_COUNT) return;
    idx  = x * PAGE_COUNT + (y >> 3);
    mask = 8'(1 << (y & 7));
    if (lit) shadow_frame[idx] = shadow_frame[idx] | mask;
    else     shadow_frame[idx] = shadow_frame[idx] & ~mask;
  endfunction

  // Apply one command to the shadow frame and build the reply it earns
  function automatic reply_t execute_command(input logic [2:0] mode, input int x, input int y,
                                             input int w, input int h, input bit color,
                                             input int index);
    reply_t r;
    r = '0;
    case (mode)
      MODE_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) shadow_frame[i] = color ? 8'hFF : 8'h00;
      end
      MODE_RECT: begin
        if (w != 0 && h != 0) begin
          if (color) begin
            // outline: top and bottom rows, then left and right columns
            for (int i = x; i < x + w; i++) begin
              plot(i, y, 1'b1);
              plot(i, y + h - 1, 1'b1);
            end
            for (int j = y; j < y + h; j++) begin
              plot(x, j, 1'b1);
              plot(x + w - 1, j, 1'b1);
            end
          end else begin
            for (int i = x; i < x + w; i++)
              for (int j = y; j < y + h; j++) plot(i, j, 1'b0);
          end
        end
      end
      MODE_SQUARE: begin
        for (int i = 0; i < SQUARE_SIDE; i++)
          for (int j = 0; j < SQUARE_SIDE; j++) plot(x + j, y + i, 1'b1);
      end
      MODE_PIXEL: plot(x, y, color);
      MODE_READ: begin
        r.is_read = 1'b1;
        if (index < STORE_BYTES) r.read_data = shadow_frame[index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Compare replies first, then predict the command taken on the same edge
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      expected_replies.delete();
      fail_count  = 0;
      cmd_count   = 0;
      reply_count = 0;
      lit_reads   = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        reply_count++;
        if (out_mon.is_read && out_mon.read_data != 8'h00) lit_reads++;
        if (expected_replies.size() == 0) begin
          fail_count++;
          $display("[%0t] unexpected reply: read_data %h is_read %b", $time,
                   out_mon.read_data, out_mon.is_read);
        end else begin
          want = expected_replies.pop_front();
          if (out_mon.read_data !== want.read_data) begin
            fail_count++;
            $display("[%0t] read_data mismatch: expected %h, actual %h", $time,
                     want.read_data, out_mon.read_data);
          end
          if (out_mon.is_read !== want.is_read) begin
            fail_count++;
            $display("[%0t] is_read mismatch: expected %b, actual %b", $time,
                     want.is_read, out_mon.is_read);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        cmd_count++;
        expected_replies.push_back(execute_command(in_mon.mode, int'(in_mon.pos_x),
                                   int'(in_mon.pos_y), int'(in_mon.rect_width),
                                   int'(in_mon.rect_height), in_mon.color,
                                   int'(in_mon.byte_index)));
      end
    end
    pending = expected_replies.size();
  end

endmodule

`default_nettype wire

### bench/mono_framebuffer_draw_engine_test.sv
`default_nettype none

module mono_framebuffer_draw_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfde_pkg::*;

  localparam int         ITEM_TOTAL   = 580;
  localparam int         PHASE_COUNT  = 4;
  localparam int         HOLD_CYCLES  = 1500;
  localparam int         QUIET_LIMIT  = 20000;
  localparam int         DRAIN_CYCLES = 64;
  localparam logic [2:0] MODE_LAST    = 3'd7;

  typedef struct {
    logic [2:0] mode;
    logic [6:0] x;
    logic [5:0] y;
    logic [7:0] w;
    logic [6:0] h;
    logic       color;
    logic [9:0] index;
  } draw_cmd_t;

  logic clk;
  logic rst_n;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  bit   hold_request = 1'b0;
  int   fail_count;
  int   pending;
  int   cmd_count;
  int   reply_count;
  int   lit_reads;

  mfde_in_if  in_ch ();
  mfde_out_if out_ch ();

  mono_framebuffer_draw_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mfde_draw_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .cmd_count   (cmd_count),
    .reply_count (reply_count),
    .lit_reads   (lit_reads)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run after too long without any item moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic draw_cmd_t make_cmd(input logic [2:0] mode, input int x, input int y,
                                         input int w, input int h, input bit color,
                                         input int index);
    draw_cmd_t c;
    c.mode  = mode;
    c.x     = 7'(x);
    c.y     = 6'(y);
    c.w     = 8'(w);
    c.h     = 7'(h);
    c.color = color;
    c.index = 10'(index);
    return c;
  endfunction

  // Mostly small shapes and reads; a few clears, panel-sized rectangles and unused modes
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int        pick;
    c.x     = 7'($urandom);
    c.y     = 6'($urandom);
    c.w     = 8'($urandom);
    c.h     = 7'($urandom);
    c.color = 1'($urandom);
    c.index = 10'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 2) begin
      c.mode = MODE_CLEAR;
    end else if (pick < 30) begin
      c.mode = MODE_RECT;
      if ($urandom_range(0, 9) != 0) begin
        c.w = 8'($urandom_range(0, 24));
        c.h = 7'($urandom_range(0, 24));
      end
    end else if (pick < 45) begin
      c.mode = MODE_SQUARE;
    end else if (pick < 65) begin
      c.mode = MODE_PIXEL;
    end else if (pick < 95) begin
      c.mode = MODE_READ;
    end else begin
      c.mode = 3'($urandom_range(int'(MODE_READ) + 1, int'(MODE_LAST)));
    end
    return c;
  endfunction

  // Offer one item after an optional gap; return on the falling edge after it is taken
  task automatic send_cmd(input draw_cmd_t c);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= c.mode;
    in_ch.pos_x       <= c.x;
    in_ch.pos_y       <= c.y;
    in_ch.rect_width  <= c.w;
    in_ch.rect_height <= c.h;
    in_ch.color       <= c.color;
    in_ch.byte_index  <= c.index;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    draw_cmd_t directed [$];

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_CLEAR;
    in_ch.pos_x       = '0;
    in_ch.pos_y       = '0;
    in_ch.rect_width  = '0;
    in_ch.rect_height = '0;
    in_ch.color       = 1'b0;
    in_ch.byte_index  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Corners of the store, clipping, empty rectangles, fills and unused modes
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 1023));
    directed.push_back(make_cmd(MODE_PIXEL,  0,   0,   0,   0,   1, 0));
    directed.push_back(make_cmd(MODE_PIXEL,  127, 63,  0,   0,   1, 0));
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 1023));
    directed.push_back(make_cmd(MODE_PIXEL,  0,   0,   0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_SQUARE, 0,   0,   0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_SQUARE, 124, 60,  0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 1023));
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_RECT,   0,   0,   128, 64,  1, 0));
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 7));
    directed.push_back(make_cmd(MODE_RECT,   100, 40,  255, 127, 1, 0));
    directed.push_back(make_cmd(MODE_RECT,   5,   5,   0,   20,  1, 0));
    directed.push_back(make_cmd(MODE_RECT,   5,   5,   20,  0,   1, 0));
    directed.push_back(make_cmd(MODE_RECT,   0,   0,   20,  20,  0, 0));
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_CLEAR,  0,   0,   0,   0,   1, 0));
    directed.push_back(make_cmd(MODE_PIXEL,  64,  32,  0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_READ,   0,   0,   0,   0,   0, 516));
    directed.push_back(make_cmd(3'd5,        127, 63,  255, 127, 1, 1023));
    directed.push_back(make_cmd(3'd6,        0,   0,   0,   0,   0, 0));
    directed.push_back(make_cmd(MODE_LAST,   85,  42,  170, 85,  1, 682));
    directed.push_back(make_cmd(MODE_CLEAR,  0,   0,   0,   0,   0, 0));
    foreach (directed[i]) send_cmd(directed[i]);

    // Random commands under four idling patterns; hold off results early on
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          idle_pct     = 0;
          stall_pct    = 0;
          hold_request = 1'b1;
        end
        1: begin
          idle_pct  = 63;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 63;
        end
        default: begin
          idle_pct  = 24;
          stall_pct = 24;
        end
      endcase
      repeat (ITEM_TOTAL / PHASE_COUNT) send_cmd(random_cmd());
    end

    // Drain outstanding replies, then watch a while for strays
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Drove %0d commands (clears, outlines, fills, squares, pixels, reads, unused modes)",
             cmd_count);
    $display("Checked %0d replies, %0d reads returned lit pixels, with one %0d-cycle hold-off",
             reply_count, lit_reads, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/mfde_pkg.sv
rtl/core/mfde_if.sv
rtl/core/mfde_front.sv
rtl/core/mfde_queue.sv
rtl/core/mfde_back.sv
rtl/core/mono_framebuffer_draw_engine.sv
bench/mfde_draw_checker.sv
bench/mono_framebuffer_draw_engine_test.sv
